// ----- sv/rews_pkg.sv -----
// ----------------------------------------------------------------------------
// rews_pkg
// Shared constants and types for the raster error statistics block.
// ----------------------------------------------------------------------------
package rews_pkg;

  localparam int unsigned MAX_SIDE  = 4096;
  localparam int unsigned SIDE_W    = 13;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned BORDER    = 2;
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned COUNT_W   = 25;
  localparam int unsigned DIVISOR_W = 26;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_NODATA_A = 2'd2,
    CFG_NODATA_B = 2'd3
  } cfg_idx_e;

  // classified pixel word passed from front to back
  typedef struct packed {
    logic [32:0] diff;      // signed first - second
    logic [31:0] abs_diff;  // |diff|, zero when not kept
    logic        kept;
    logic        last;
  } item_t;

endpackage

// ----- sv/rews_front.sv -----
// ----------------------------------------------------------------------------
// rews_front
// Configuration registers, raster position tracking and pixel classification.
// ----------------------------------------------------------------------------
module rews_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                take_i,
  input  logic [31:0]         sample_first_i,
  input  logic [31:0]         sample_second_i,
  output rews_pkg::item_t     item_o
);
  import rews_pkg::*;

  logic [SIDE_W-1:0] width_q, height_q;
  logic [31:0]       nodata_a_q, nodata_b_q;
  logic [POS_W-1:0]  row_q, col_q;
  logic [SIDE_W-1:0] w_eff, h_eff;
  logic [SIDE_W:0]   row_x, col_x;
  logic              in_area, kept, last_col, last;
  logic [32:0]       diff, mag;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= SIDE_W'(MAX_SIDE);
      height_q   <= SIDE_W'(MAX_SIDE);
      nodata_a_q <= 32'hFE796100;
      nodata_b_q <= 32'hFE796100;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:    width_q    <= cfg_data_i[SIDE_W-1:0];
        CFG_HEIGHT:   height_q   <= cfg_data_i[SIDE_W-1:0];
        CFG_NODATA_A: nodata_a_q <= cfg_data_i;
        CFG_NODATA_B: nodata_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp sizes into 1..MAX_SIDE
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) w_eff = SIDE_W'(1);
    else if (width_q > SIDE_W'(MAX_SIDE)) w_eff = SIDE_W'(MAX_SIDE);
    h_eff = height_q;
    if (height_q == '0) h_eff = SIDE_W'(1);
    else if (height_q > SIDE_W'(MAX_SIDE)) h_eff = SIDE_W'(MAX_SIDE);
  end

  // classify
  always_comb begin
    row_x    = {2'b00, row_q};
    col_x    = {2'b00, col_q};
    in_area  = (row_x >= (SIDE_W+1)'(BORDER)) && (row_x + (SIDE_W+1)'(BORDER) < {1'b0, h_eff})
            && (col_x >= (SIDE_W+1)'(BORDER)) && (col_x + (SIDE_W+1)'(BORDER) < {1'b0, w_eff});
    kept     = in_area && (sample_first_i != nodata_a_q) && (sample_second_i != nodata_b_q);
    last_col = (col_x + (SIDE_W+1)'(1)) >= {1'b0, w_eff};
    last     = last_col && ((row_x + (SIDE_W+1)'(1)) >= {1'b0, h_eff});
    diff     = {sample_first_i[31], sample_first_i} - {sample_second_i[31], sample_second_i};
    mag      = diff[32] ? (33'd0 - diff) : diff;
    item_o.diff     = diff;
    item_o.abs_diff = kept ? mag[31:0] : 32'd0;
    item_o.kept     = kept;
    item_o.last     = last;
  end

  // raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (take_i) begin
      if (last) begin
        row_q <= '0;
        col_q <= '0;
      end else if (last_col) begin
        col_q <= '0;
        row_q <= row_q + POS_W'(1);
      end else begin
        col_q <= col_q + POS_W'(1);
      end
    end
  end

endmodule

// ----- sv/rews_fifo.sv -----
// ----------------------------------------------------------------------------
// rews_fifo
// Two-entry queue of classified pixel words between front and back.
// ----------------------------------------------------------------------------
module rews_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rews_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output rews_pkg::item_t data_o
);
  import rews_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/rews_div.sv -----
// ----------------------------------------------------------------------------
// rews_div
// Restoring unsigned divider, 64-bit dividend by 26-bit divisor, one bit
// per cycle.
// ----------------------------------------------------------------------------
module rews_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [63:0]                    dividend_i,
  input  logic [rews_pkg::DIVISOR_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [63:0]                    quotient_o
);
  import rews_pkg::*;

  logic [DIVISOR_W:0]   rem_q, shifted, rem_d;
  logic [DIVISOR_W-1:0] div_q;
  logic [63:0]          quo_q;
  logic [5:0]           cnt_q;
  logic                 busy_q, done_q, fits;

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_comb begin
    shifted = {rem_q[DIVISOR_W-1:0], quo_q[63]};
    fits    = shifted >= {1'b0, div_q};
    rem_d   = fits ? (shifted - {1'b0, div_q}) : shifted;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[62:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/rews_back.sv -----
// ----------------------------------------------------------------------------
// rews_back
// Welford update, frame statistics and result register.
// ----------------------------------------------------------------------------
module rews_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fifo_valid_i,
  input  rews_pkg::item_t fifo_data_i,
  output logic            fifo_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [31:0]     error_abs_o,
  output logic            error_valid_o,
  output logic            frame_done_o,
  output logic [32:0]     mean_error_o,
  output logic [31:0]     std_error_o,
  output logic [31:0]     peak_error_o,
  output logic [24:0]     compared_count_o
);
  import rews_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WSTART, S_WWAIT, S_MUL, S_UPD, S_FIN, S_MWAIT,
    S_SSTART, S_SWAIT, S_SQRT, S_EMIT
  } state_e;

  state_e state_q;
  item_t  it_q;
  logic [63:0] mean_q, spread_q, dsum_q;
  logic [COUNT_W-1:0] count_q;
  logic [31:0] largest_q;
  logic [63:0] a_q, b_q, dm_q;
  logic [127:0] acc_q;
  logic [1:0]  mstep_q;
  logic [63:0] n_q, r_q, bit_q;
  logic [4:0]  sq_cnt_q;
  logic [32:0] mean_res_q;

  logic [31:0] out_abs_q, out_max_q, out_std_q;
  logic        out_valid_q, out_ev_q, out_fd_q;
  logic [32:0] out_mean_q;
  logic [24:0] out_cnt_q;

  // datapath helpers
  logic [63:0] x, dm, dm_mag, dsum_mag, quo, q_signed, new_m, xn, xn_mag, inc, sp_sum, t;
  logic [64:0] sp_add;
  logic [31:0] pa, pb;
  logic [63:0] prod;
  logic [127:0] prod_sh;
  logic        div_start, div_done, slot_free, emit, stats_out;
  logic [63:0] div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;

  assign fifo_pop_o = (state_q == S_IDLE) && fifo_valid_i;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign emit       = (state_q == S_EMIT) && slot_free;
  assign stats_out  = it_q.last && (count_q != '0);

  always_comb begin
    x        = {{15{it_q.diff[32]}}, it_q.diff, 16'd0};
    dm       = x - mean_q;
    dm_mag   = dm[63] ? (64'd0 - dm) : dm;
    dsum_mag = dsum_q[63] ? (64'd0 - dsum_q) : dsum_q;
    q_signed = dm_q[63] ? (64'd0 - quo) : quo;
    new_m    = mean_q + q_signed;
    xn       = x - new_m;
    xn_mag   = xn[63] ? (64'd0 - xn) : xn;
    // one 32x32 partial product per cycle
    pa       = mstep_q[1] ? a_q[63:32] : a_q[31:0];
    pb       = mstep_q[0] ? b_q[63:32] : b_q[31:0];
    prod     = 64'(pa) * 64'(pb);
    case (mstep_q)
      2'd0:    prod_sh = {64'd0, prod};
      2'd3:    prod_sh = {prod, 64'd0};
      default: prod_sh = {32'd0, prod, 32'd0};
    endcase
    inc      = (acc_q[127:96] != '0) ? '1 : acc_q[95:32];
    sp_add   = {1'b0, spread_q} + {1'b0, inc};
    sp_sum   = sp_add[64] ? '1 : sp_add[63:0];
    t        = r_q + bit_q;
    // divider operands
    div_start    = (state_q == S_WSTART) || (state_q == S_SSTART)
                || ((state_q == S_FIN) && (count_q != '0));
    div_dividend = (state_q == S_WSTART) ? dm_mag
                 : (state_q == S_SSTART) ? spread_q : dsum_mag;
    div_divisor  = (state_q == S_WSTART) ? ({1'b0, count_q} + DIVISOR_W'(1))
                                         : {1'b0, count_q};
  end

  rews_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // sequencer with state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mean_q      <= '0;
      spread_q    <= '0;
      dsum_q      <= '0;
      count_q     <= '0;
      largest_q   <= '0;
    end else begin
      // result valid: set on emit, dropped once taken
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (fifo_valid_i) begin
            it_q <= fifo_data_i;
            if (fifo_data_i.kept)      state_q <= S_WSTART;
            else if (fifo_data_i.last) state_q <= S_FIN;
            else                       state_q <= S_EMIT;
          end
        end
        S_WSTART: begin
          dm_q    <= dm;
          b_q     <= dm_mag;
          state_q <= S_WWAIT;
        end
        S_WWAIT: begin
          if (div_done) begin
            mean_q  <= new_m;
            a_q     <= xn_mag;
            acc_q   <= '0;
            mstep_q <= 2'd0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          acc_q   <= acc_q + prod_sh;
          mstep_q <= mstep_q + 2'd1;
          if (mstep_q == 2'd3) state_q <= S_UPD;
        end
        S_UPD: begin
          spread_q <= sp_sum;
          dsum_q   <= dsum_q + {{31{it_q.diff[32]}}, it_q.diff};
          if (it_q.abs_diff > largest_q) largest_q <= it_q.abs_diff;
          if (count_q != '1) count_q <= count_q + COUNT_W'(1);
          state_q  <= it_q.last ? S_FIN : S_EMIT;
        end
        S_FIN: begin
          if (count_q == '0) begin
            mean_res_q <= '0;
            state_q    <= S_EMIT;
          end else begin
            state_q    <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (div_done) begin
            mean_res_q <= dsum_q[63] ? (33'd0 - quo[32:0]) : quo[32:0];
            state_q    <= S_SSTART;
          end
        end
        S_SSTART: state_q <= S_SWAIT;
        S_SWAIT: begin
          if (div_done) begin
            n_q      <= quo;
            r_q      <= '0;
            bit_q    <= 64'h4000_0000_0000_0000;
            sq_cnt_q <= '0;
            state_q  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (n_q >= t) begin
            n_q <= n_q - t;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q    <= bit_q >> 2;
          sq_cnt_q <= sq_cnt_q + 5'd1;
          if (sq_cnt_q == 5'd31) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_abs_q  <= it_q.abs_diff;
            out_ev_q   <= it_q.kept;
            out_fd_q   <= it_q.last;
            out_mean_q <= stats_out ? mean_res_q : '0;
            out_std_q  <= stats_out ? r_q[31:0] : '0;
            out_max_q  <= stats_out ? largest_q : '0;
            out_cnt_q  <= stats_out ? count_q : '0;
            if (it_q.last) begin
              mean_q    <= '0;
              spread_q  <= '0;
              dsum_q    <= '0;
              count_q   <= '0;
              largest_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign error_abs_o      = out_abs_q;
  assign error_valid_o    = out_ev_q;
  assign frame_done_o     = out_fd_q;
  assign mean_error_o     = out_mean_q;
  assign std_error_o      = out_std_q;
  assign peak_error_o     = out_max_q;
  assign compared_count_o = out_cnt_q;

endmodule

// ----- sv/raster_error_welford_statistics_top.sv -----
// ----------------------------------------------------------------------------
// raster_error_welford_statistics_top
// Per-pixel error map and frame statistics of two co-located rasters.
// ----------------------------------------------------------------------------
// Input channel: one word per pixel (sample_first_i, sample_second_i), Q24.8,
//   in raster order; taken when in_valid_i is high and in_stall_o is low.
// Output channel: one word per pixel with the absolute error and, on the
//   last pixel of a raster, mean, standard deviation, maximum and count.
// Config channel: cfg_index_i selects width, height or a no-data marker;
//   cfg_ready_o is always high. Write only while the block is idle.
// Back end: it takes a new word from the queue only when idle. A border or
//   no-data pixel goes straight to the result register; a compared pixel
//   waits for the bit-serial divider of the running-mean update and then
//   for the partial products. The last pixel, if any pixel was compared,
//   adds two more divisions and a 32-step square root.
// The front end classifies pixels and queues up to two words, so input is
//   taken while the back end works or the output waits, until the queue fills.
// Reset: sizes 4096x4096, no-data markers -99999.0, position and
//   statistics cleared. A stalled result holds until taken.
// ----------------------------------------------------------------------------
module raster_error_welford_statistics_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_first_i,
  input  logic [31:0] sample_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] error_abs_o,
  output logic        error_valid_o,
  output logic        frame_done_o,
  output logic [32:0] mean_error_o,
  output logic [31:0] std_error_o,
  output logic [31:0] peak_error_o,
  output logic [24:0] compared_count_o
);
  import rews_pkg::*;

  item_t front_item, fifo_item;
  logic  fifo_full, fifo_valid, fifo_pop, take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = fifo_full;
  assign take        = in_valid_i && !fifo_full;

  rews_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .take_i          (take),
    .sample_first_i  (sample_first_i),
    .sample_second_i (sample_second_i),
    .item_o          (front_item)
  );

  rews_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .data_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_item)
  );

  rews_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fifo_valid_i     (fifo_valid),
    .fifo_data_i      (fifo_item),
    .fifo_pop_o       (fifo_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .error_abs_o      (error_abs_o),
    .error_valid_o    (error_valid_o),
    .frame_done_o     (frame_done_o),
    .mean_error_o     (mean_error_o),
    .std_error_o      (std_error_o),
    .peak_error_o     (peak_error_o),
    .compared_count_o (compared_count_o)
  );

endmodule

// ----- sv/rews_checker.sv -----
// ----------------------------------------------------------------------------
// rews_checker
// Port-level checks of the raster error statistics block.
// ----------------------------------------------------------------------------
module rews_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] error_abs_o,
  input logic        error_valid_o,
  input logic        frame_done_o,
  input logic [32:0] mean_error_o,
  input logic [31:0] std_error_o,
  input logic [31:0] peak_error_o,
  input logic [24:0] compared_count_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(error_abs_o)
      && $stable(frame_done_o) && $stable(compared_count_o))
    else $error("stalled result changed");

  // statistics are zero except on the last pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> mean_error_o == '0 && std_error_o == '0
      && peak_error_o == '0 && compared_count_o == '0)
    else $error("statistics outside frame end");

  // uncompared pixels carry no error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_valid_o |-> error_abs_o == '0)
    else $error("error on uncompared pixel");

  // a compared last pixel is counted and bounded by the maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o && error_valid_o |->
      compared_count_o != '0 && peak_error_o >= error_abs_o)
    else $error("frame maximum below last error");

endmodule

bind raster_error_welford_statistics_top rews_checker u_rews_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .error_abs_o      (error_abs_o),
  .error_valid_o    (error_valid_o),
  .frame_done_o     (frame_done_o),
  .mean_error_o     (mean_error_o),
  .std_error_o      (std_error_o),
  .peak_error_o     (peak_error_o),
  .compared_count_o (compared_count_o)
);
